@@ rtl/core/pip_pkg.sv @@
// Package for the point-in-polygon crossing-number block.
// Holds sizes, action and status codes, payload structs and scaling helpers.
// Depends on nothing; every other file of the block uses it.
package pip_pkg;

  // Sizes
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  // Coordinate difference, scaled coordinate, product and compare widths.
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int SCL_W        = COORD_BITS + 9;
  localparam int PROD_W       = SCL_W + DIFF_W;
  localparam int CMP_W        = PROD_W + 1;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  // Request from the sequencer to the vertex store.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    vertex_t           wr_vtx;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } vs_req_t;

  // Sign-extend a coordinate to the scaled width.
  function automatic logic signed [SCL_W-1:0] sext_scl(input logic signed [COORD_BITS-1:0] v);
    return {{(SCL_W-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  // Difference of two coordinates, one bit wider so that it never wraps.
  function automatic logic signed [DIFF_W-1:0] coord_diff(input logic signed [COORD_BITS-1:0] a,
                                                          input logic signed [COORD_BITS-1:0] b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  // Multiply by one hundred with shifts and adds: 64 + 32 + 4.
  function automatic logic signed [SCL_W-1:0] times100(input logic signed [SCL_W-1:0] v);
    return (v <<< 6) + (v <<< 5) + (v <<< 2);
  endfunction

endpackage

@@ rtl/core/point_in_polygon_ray_cast.sv @@
// Top level of the point-in-polygon block: sequencer, polygon bookkeeping and edge tests.
// Depends on pip_pkg, pip_vstore and pip_mul.
//
// Use: items arrive on in_valid/in_ready/in_data and each gives exactly one result
// on out_valid/out_ready/out_data. An item clears the polygon, appends a vertex,
// or queries a point; the result carries inside_res and status.
// Clear, append, a full-store append, an empty query and the unused action go
// straight to S_DONE, which raises out_valid once the output register is free.
// A query first fetches the first two vertices through S_RD and S_CAP, or just the
// vertex of a lone-vertex polygon; then each edge, closing edge included,
// passes S_M1, S_M2, S_M3 and S_EVAL for three products from the single shared
// multiplier and an evaluation, while the next vertex is fetched over the store's
// read port, and the result goes through S_DONE. The block takes one item at a
// time; in_ready is high only while the sequencer is idle, so a new item is taken
// only after S_DONE has handed the result on. A finished result sits in an output
// register, so the next item is accepted while that result waits. If the receiver
// stalls with a result already held, the following result waits in the sequencer
// until the register frees, and in_ready stays low meanwhile.
// Reset empties the polygon and drops any pending result; the vertex store needs
// no clearing, since data read from unwritten entries is never used.
module point_in_polygon_ray_cast (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pip_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pip_pkg::out_item_t out_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_CAP  = 8'b0000_0100,
    S_M1   = 8'b0000_1000,
    S_M2   = 8'b0001_0000,
    S_M3   = 8'b0010_0000,
    S_EVAL = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [pip_pkg::CNT_W-1:0]              count_r, count_nxt;
  logic signed [pip_pkg::COORD_BITS-1:0]  least_r, least_nxt;
  logic signed [pip_pkg::COORD_BITS-1:0]  greatest_r, greatest_nxt;
  logic signed [pip_pkg::SCL_W-1:0]       px100_r, px100_nxt;
  logic signed [pip_pkg::SCL_W-1:0]       ex100_r, ex100_nxt;
  logic signed [pip_pkg::COORD_BITS-1:0]  py_r, py_nxt;
  logic                                   dir_nz_r, dir_nz_nxt;
  logic [pip_pkg::CNT_W-1:0]              idx_r, idx_nxt;
  logic                                   last_r, last_nxt;
  logic                                   parity_r, parity_nxt;
  pip_pkg::vertex_t                       first_r, first_nxt;
  pip_pkg::vertex_t                       a_r, a_nxt;
  pip_pkg::vertex_t                       b_r, b_nxt;
  logic signed [pip_pkg::PROD_W-1:0]      t2_r, t2_nxt;
  logic signed [pip_pkg::PROD_W-1:0]      t1p_r, t1p_nxt;
  pip_pkg::out_item_t                     res_r, res_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  pip_pkg::out_item_t                     out_data_r, out_data_nxt;

  pip_pkg::vs_req_t                       vs_req;
  pip_pkg::vertex_t                       rd_vtx;
  logic signed [pip_pkg::SCL_W-1:0]       mul_a;
  logic signed [pip_pkg::DIFF_W-1:0]      mul_b;
  logic signed [pip_pkg::PROD_W-1:0]      prod;

  // Edge operands and evaluation terms
  logic signed [pip_pkg::DIFF_W-1:0]      dy;
  logic signed [pip_pkg::DIFF_W-1:0]      dpy;
  logic signed [pip_pkg::SCL_W-1:0]       dx100;
  logic signed [pip_pkg::SCL_W-1:0]       ax100;
  logic signed [pip_pkg::SCL_W-1:0]       in_px100;
  logic signed [pip_pkg::SCL_W-1:0]       in_ex100;
  logic signed [pip_pkg::CMP_W-1:0]       d_p;
  logic signed [pip_pkg::CMP_W-1:0]       d_e;
  logic                                   rej_line;
  logic                                   rej_ray;
  logic                                   hit;
  logic [pip_pkg::CNT_W-1:0]              idx_inc;
  logic                                   out_free;

  pip_vstore u_vstore (
    .clk     (clk),
    .req     (vs_req),
    .rd_data (rd_vtx)
  );

  pip_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_inc   = idx_r + pip_pkg::CNT_W'(1);

  // Scaled query point and the exact scaled ray end, from the current x extent.
  assign in_px100 = pip_pkg::times100(pip_pkg::sext_scl(in_data.point_x));
  assign in_ex100 = pip_pkg::times100(pip_pkg::sext_scl(least_r))
                  - (pip_pkg::sext_scl(greatest_r) - pip_pkg::sext_scl(least_r));

  // Edge terms from the current edge (a to b).
  assign dy    = pip_pkg::coord_diff(b_r.y, a_r.y);
  assign dpy   = pip_pkg::coord_diff(py_r, a_r.y);
  assign dx100 = pip_pkg::times100(pip_pkg::SCL_W'(pip_pkg::coord_diff(b_r.x, a_r.x)));
  assign ax100 = pip_pkg::times100(pip_pkg::sext_scl(a_r.x));

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      S_M2: begin
        mul_a = px100_r - ax100;
        mul_b = dy;
      end
      S_M3: begin
        mul_a = ex100_r - ax100;
        mul_b = dy;
      end
      default: begin
        mul_a = dx100;
        mul_b = dpy;
      end
    endcase
  end

  // Side tests: the product in the evaluation cycle is the ray-end term.
  assign d_p = {t1p_r[pip_pkg::PROD_W-1], t1p_r} - {t2_r[pip_pkg::PROD_W-1], t2_r};
  assign d_e = {prod[pip_pkg::PROD_W-1], prod} - {t2_r[pip_pkg::PROD_W-1], t2_r};
  assign rej_line = (d_p != '0) && (d_e != '0) &&
                    (d_p[pip_pkg::CMP_W-1] == d_e[pip_pkg::CMP_W-1]);
  assign rej_ray  = dir_nz_r && (((a_r.y > py_r) && (b_r.y > py_r)) ||
                                 ((a_r.y < py_r) && (b_r.y < py_r)));
  assign hit      = !rej_line && !rej_ray;

  // Sequencer and bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    least_nxt     = least_r;
    greatest_nxt  = greatest_r;
    px100_nxt     = px100_r;
    ex100_nxt     = ex100_r;
    py_nxt        = py_r;
    dir_nz_nxt    = dir_nz_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    parity_nxt    = parity_r;
    first_nxt     = first_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t2_nxt        = t2_r;
    t1p_nxt       = t1p_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    vs_req.wr_en       = 1'b0;
    vs_req.wr_addr     = count_r[pip_pkg::ADDR_W-1:0];
    vs_req.wr_vtx.x    = in_data.point_x;
    vs_req.wr_vtx.y    = in_data.point_y;
    vs_req.rd_en       = 1'b0;
    vs_req.rd_addr     = idx_r[pip_pkg::ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt.inside_res = 1'b0;
          res_nxt.status     = pip_pkg::ST_OK;
          state_nxt          = S_DONE;
          case (in_data.action)
            pip_pkg::ACT_CLEAR: begin
              count_nxt    = '0;
              least_nxt    = pip_pkg::COORD_MAX;
              greatest_nxt = pip_pkg::COORD_MIN;
            end
            pip_pkg::ACT_APPEND: begin
              if (count_r == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES)) begin
                res_nxt.status = pip_pkg::ST_FULL;
              end else begin
                vs_req.wr_en = 1'b1;
                count_nxt    = count_r + pip_pkg::CNT_W'(1);
                if (in_data.point_x < least_r) begin
                  least_nxt = in_data.point_x;
                end
                if (in_data.point_x > greatest_r) begin
                  greatest_nxt = in_data.point_x;
                end
              end
            end
            pip_pkg::ACT_QUERY: begin
              if (count_r == '0) begin
                res_nxt.status = pip_pkg::ST_EMPTY;
              end else begin
                px100_nxt  = in_px100;
                ex100_nxt  = in_ex100;
                py_nxt     = in_data.point_y;
                dir_nz_nxt = (in_px100 != in_ex100);
                idx_nxt    = '0;
                last_nxt   = 1'b0;
                parity_nxt = 1'b0;
                state_nxt  = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        vs_req.rd_en = 1'b1;
        state_nxt    = S_CAP;
      end
      S_CAP: begin
        if (idx_r == '0) begin
          first_nxt = rd_vtx;
          a_nxt     = rd_vtx;
          if (count_r == pip_pkg::CNT_W'(1)) begin
            // A lone vertex: only the closing edge, from the vertex to itself.
            b_nxt     = rd_vtx;
            last_nxt  = 1'b1;
            state_nxt = S_M1;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_RD;
          end
        end else begin
          b_nxt     = rd_vtx;
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        // Prefetch the vertex after b while the products are formed.
        vs_req.rd_en   = 1'b1;
        vs_req.rd_addr = idx_inc[pip_pkg::ADDR_W-1:0];
        state_nxt      = S_M2;
      end
      S_M2: begin
        t2_nxt    = prod;
        state_nxt = S_M3;
      end
      S_M3: begin
        t1p_nxt   = prod;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        parity_nxt = parity_r ^ hit;
        if (last_r) begin
          res_nxt.inside_res = parity_r ^ hit;
          res_nxt.status     = pip_pkg::ST_OK;
          state_nxt          = S_DONE;
        end else begin
          a_nxt   = b_r;
          idx_nxt = idx_inc;
          if (idx_inc == count_r) begin
            // Closing edge back to the first vertex.
            b_nxt    = first_r;
            last_nxt = 1'b1;
          end else begin
            b_nxt = rd_vtx;
          end
          state_nxt = S_M1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      least_r     <= pip_pkg::COORD_MAX;
      greatest_r  <= pip_pkg::COORD_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      least_r     <= least_nxt;
      greatest_r  <= greatest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    px100_r    <= px100_nxt;
    ex100_r    <= ex100_nxt;
    py_r       <= py_nxt;
    dir_nz_r   <= dir_nz_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    parity_r   <= parity_nxt;
    first_r    <= first_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t2_r       <= t2_nxt;
    t1p_r      <= t1p_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/core/pip_mul.sv @@
// Shared signed multiplier of the point-in-polygon block, with a registered product.
// Depends on pip_pkg for the operand and product widths.
module pip_mul (
  input  logic                              clk,
  input  logic signed [pip_pkg::SCL_W-1:0]  mul_a,
  input  logic signed [pip_pkg::DIFF_W-1:0] mul_b,
  output logic signed [pip_pkg::PROD_W-1:0] prod
);

  logic signed [pip_pkg::PROD_W-1:0] prod_r;

  // One product per cycle, ready in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

@@ rtl/core/pip_vstore.sv @@
// Vertex store of the point-in-polygon block: one write and one registered read a cycle.
// Depends on pip_pkg for the vertex type and the store request struct.
module pip_vstore (
  input  logic             clk,
  input  pip_pkg::vs_req_t req,
  output pip_pkg::vertex_t rd_data
);

  pip_pkg::vertex_t mem [pip_pkg::MAX_VERTICES];
  pip_pkg::vertex_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_vtx;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/sv/pip_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the point-in-polygon crossing-number block: it keeps its own polygon and
// predicts each verdict. Depends on pip_pkg for the payload types and codes.
package pip_scoreboard_pkg;

  // Query coordinates are scaled by this factor so that the ray end point is exact.
  localparam longint COORD_SCALE = 100;

  class polygon_scoreboard;
    longint             corner_x[pip_pkg::MAX_VERTICES];
    longint             corner_y[pip_pkg::MAX_VERTICES];
    int                 corner_count;
    longint             least_x;
    longint             greatest_x;
    pip_pkg::out_item_t expected_verdicts[$];
    int                 failures;
    int                 reported;

    function new();
      clear_polygon();
      failures = 0;
      reported = 0;
    endfunction

    function void clear_polygon();
      corner_count = 0;
      least_x      = $signed(pip_pkg::COORD_MAX);
      greatest_x   = $signed(pip_pkg::COORD_MIN);
    endfunction

    function int signum(input longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    // Side of the point (x100 / 100, y) relative to the line through a and b.
    function int side_of_line(input longint ax, ay, bx, by, x100, y);
      longint t1;
      longint t2;
      t1 = (by - ay) * (x100 - COORD_SCALE * ax);
      t2 = COORD_SCALE * (bx - ax) * (y - ay);
      return signum(t1 - t2);
    endfunction

    // Only two points strictly on the same side rule a crossing out.
    function bit straddles(input int s1, input int s2);
      return !((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0));
    endfunction

    function bit edge_crosses_ray(input int a, input int b, input longint px, input longint py,
                                  input longint end100);
      int s1;
      int s2;
      int dir;
      s1 = side_of_line(corner_x[a], corner_y[a], corner_x[b], corner_y[b],
                        COORD_SCALE * px, py);
      s2 = side_of_line(corner_x[a], corner_y[a], corner_x[b], corner_y[b], end100, py);
      if (!straddles(s1, s2)) return 1'b0;
      // The ray is horizontal, so the side of a vertex follows from its y alone.
      dir = signum(COORD_SCALE * px - end100);
      s1  = dir * signum(corner_y[a] - py);
      s2  = dir * signum(corner_y[b] - py);
      return straddles(s1, s2);
    endfunction

    // Works out the verdict for one item and updates the polygon.
    function pip_pkg::out_item_t predict_verdict(input pip_pkg::in_item_t item);
      pip_pkg::out_item_t v;
      longint             px;
      longint             py;
      longint             end100;
      bit                 parity;
      int                 k;
      px           = $signed(item.point_x);
      py           = $signed(item.point_y);
      v.inside_res = 1'b0;
      v.status     = pip_pkg::ST_OK;
      case (item.action)
        pip_pkg::ACT_CLEAR: begin
          clear_polygon();
        end
        pip_pkg::ACT_APPEND: begin
          if (corner_count >= pip_pkg::MAX_VERTICES) begin
            v.status = pip_pkg::ST_FULL;
          end else begin
            corner_x[corner_count] = px;
            corner_y[corner_count] = py;
            corner_count++;
            if (px < least_x) least_x = px;
            if (px > greatest_x) greatest_x = px;
          end
        end
        pip_pkg::ACT_QUERY: begin
          if (corner_count == 0) begin
            v.status = pip_pkg::ST_EMPTY;
          end else begin
            end100 = COORD_SCALE * least_x - (greatest_x - least_x);
            parity = 1'b0;
            for (k = 0; k + 1 < corner_count; k++) begin
              parity ^= edge_crosses_ray(k, k + 1, px, py, end100);
            end
            // The closing edge runs from the last vertex back to the first.
            parity ^= edge_crosses_ray(corner_count - 1, 0, px, py, end100);
            v.inside_res = parity;
          end
        end
        default: begin
        end
      endcase
      return v;
    endfunction

    function void note_transfer(input pip_pkg::in_item_t item);
      pip_pkg::out_item_t want;
      want              = predict_verdict(item);
      expected_verdicts = {expected_verdicts, want};
    endfunction

    function void check_result(input pip_pkg::out_item_t got);
      pip_pkg::out_item_t want;
      if (expected_verdicts.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: inside_res=%0d status=%0d", got.inside_res, got.status);
        end
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.inside_res !== want.inside_res || got.status !== want.status) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected inside_res=%0d status=%0d, got inside_res=%0d status=%0d",
                   want.inside_res, want.status, got.inside_res, got.status);
        end
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

endpackage

@@ tb/sv/point_in_polygon_ray_cast_test.sv @@
`timescale 1ns / 1ps
// Testbench top for point_in_polygon_ray_cast: directed and random polygons and queries,
// with idling and back-pressure. Depends on pip_pkg and pip_scoreboard_pkg.
module point_in_polygon_ray_cast_test;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         HOLD_LEN    = 500;
  localparam int         CYCLE_LIMIT = 1500000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pip_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pip_pkg::out_item_t out_data;

  pip_scoreboard_pkg::polygon_scoreboard verdicts = new();

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  // Vertices of the polygon being built, used to aim queries at awkward spots.
  int poly_x[$];
  int poly_y[$];
  int box_lo_x, box_hi_x, box_lo_y, box_hi_y;

  point_in_polygon_ray_cast dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every transfer on either channel is seen here at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) verdicts.note_transfer(in_data);
    if (rst_n && out_valid && out_ready) verdicts.check_result(out_data);
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Offers one item and returns once it has been transferred.
  task automatic send_item(input logic [1:0] act, input int x, input int y);
    pip_pkg::in_item_t item;
    item.action  = act;
    item.point_x = x[pip_pkg::COORD_BITS-1:0];
    item.point_y = y[pip_pkg::COORD_BITS-1:0];
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // Sender stands still until every verdict has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts.pending() != 0) @(posedge clk);
  endtask

  // Tiny boxes give many collinear and coincident points; wide ones reach every bit.
  task automatic choose_box();
    int mode;
    int cx;
    int cy;
    int r;
    mode = $urandom_range(9);
    if (mode < 3) begin
      box_lo_x = -8;
      box_hi_x = 8;
      box_lo_y = -8;
      box_hi_y = 8;
    end else if (mode < 8) begin
      cx       = pick(-20000, 20000);
      cy       = pick(-20000, 20000);
      r        = pick(1, 12000);
      box_lo_x = cx - r;
      box_hi_x = cx + r;
      box_lo_y = cy - pick(1, 12000);
      box_hi_y = cy + r;
    end else begin
      box_lo_x = -32768;
      box_hi_x = 32767;
      box_lo_y = -32768;
      box_hi_y = 32767;
    end
  endtask

  task automatic add_vertex();
    int x;
    int y;
    x = pick(box_lo_x, box_hi_x);
    y = pick(box_lo_y, box_hi_y);
    if (poly_x.size() < pip_pkg::MAX_VERTICES) begin
      poly_x = {poly_x, x};
      poly_y = {poly_y, y};
    end
    send_item(pip_pkg::ACT_APPEND, x, y);
  endtask

  // Queries land in the box, on a vertex, level with a vertex, mid-edge or anywhere.
  task automatic send_query();
    int sel;
    int k;
    int k2;
    int qx;
    int qy;
    sel = $urandom_range(99);
    if (poly_x.size() == 0 || sel < 40) begin
      qx = pick(box_lo_x, box_hi_x);
      qy = pick(box_lo_y, box_hi_y);
    end else begin
      k  = pick(0, poly_x.size() - 1);
      k2 = (k + 1) % poly_x.size();
      if (sel < 55) begin
        qx = poly_x[k];
        qy = poly_y[k];
      end else if (sel < 70) begin
        qx = pick(box_lo_x, box_hi_x);
        qy = poly_y[k];
      end else if (sel < 80) begin
        qx = (poly_x[k] + poly_x[k2]) / 2;
        qy = (poly_y[k] + poly_y[k2]) / 2;
      end else begin
        qx = pick(-32768, 32767);
        qy = pick(-32768, 32767);
      end
    end
    send_item(pip_pkg::ACT_QUERY, qx, qy);
  endtask

  // Mostly a fresh polygon followed by queries; sometimes noise or a stray append.
  task automatic run_episode();
    int sel;
    int n;
    int q;
    sel = $urandom_range(99);
    if (sel < 12) begin
      repeat (pick(1, 4)) begin
        send_item(2'($urandom_range(3)), pick(-32768, 32767), pick(-32768, 32767));
      end
      return;
    end
    choose_box();
    poly_x.delete();
    poly_y.delete();
    send_item(pip_pkg::ACT_CLEAR, pick(-32768, 32767), pick(-32768, 32767));
    sel = $urandom_range(99);
    if (sel < 65) n = pick(1, 8);
    else if (sel < 88) n = pick(9, 24);
    else if (sel < 97) n = pick(25, 63);
    else n = pick(64, 68);
    repeat (n) add_vertex();
    q = (n > 24) ? pick(1, 3) : pick(2, 8);
    repeat (q) send_query();
    // A polygon extended after it has been queried.
    if ($urandom_range(9) == 0) begin
      add_vertex();
      send_query();
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int quota);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + quota;
    while (items_sent < stop_at) run_episode();
    drain();
  endtask

  task automatic run_directed();
    // Empty polygon and the unused action.
    send_item(pip_pkg::ACT_QUERY, 0, 0);
    send_item(ACT_UNUSED, -1, -1);
    // Single vertex: the closing edge is the vertex itself, and for the first two queries the ray has no length.
    send_item(pip_pkg::ACT_APPEND, 5, 5);
    send_item(pip_pkg::ACT_QUERY, 5, 5);
    send_item(pip_pkg::ACT_QUERY, 5, 9);
    send_item(pip_pkg::ACT_QUERY, -3, 5);
    // Square on the extremes of the coordinate range.
    send_item(pip_pkg::ACT_CLEAR, pip_pkg::COORD_MAX, pip_pkg::COORD_MIN);
    send_item(pip_pkg::ACT_APPEND, pip_pkg::COORD_MIN, pip_pkg::COORD_MIN);
    send_item(pip_pkg::ACT_APPEND, pip_pkg::COORD_MAX, pip_pkg::COORD_MIN);
    send_item(pip_pkg::ACT_APPEND, pip_pkg::COORD_MAX, pip_pkg::COORD_MAX);
    send_item(pip_pkg::ACT_APPEND, pip_pkg::COORD_MIN, pip_pkg::COORD_MAX);
    send_item(pip_pkg::ACT_QUERY, 0, 0);
    send_item(pip_pkg::ACT_QUERY, pip_pkg::COORD_MAX, 0);
    send_item(pip_pkg::ACT_QUERY, pip_pkg::COORD_MIN, pip_pkg::COORD_MIN);
    send_item(pip_pkg::ACT_QUERY, pip_pkg::COORD_MAX, pip_pkg::COORD_MAX);
    send_item(pip_pkg::ACT_QUERY, -1, pip_pkg::COORD_MIN);
    // Query straight after a clear.
    send_item(pip_pkg::ACT_CLEAR, 0, 0);
    send_item(pip_pkg::ACT_QUERY, 1, 1);
    // Triangle with a repeated vertex, giving a zero-length edge.
    send_item(pip_pkg::ACT_APPEND, 0, 0);
    send_item(pip_pkg::ACT_APPEND, 10, 0);
    send_item(pip_pkg::ACT_APPEND, 0, 10);
    send_item(pip_pkg::ACT_APPEND, 0, 10);
    send_item(pip_pkg::ACT_QUERY, 2, 2);
    send_item(pip_pkg::ACT_QUERY, 5, 5);
    send_item(pip_pkg::ACT_QUERY, 10, 0);
    send_item(pip_pkg::ACT_QUERY, -1, 0);
    send_item(pip_pkg::ACT_QUERY, 20, 20);
  endtask

  // Long receiver hold-off while a full polygon is built, overfilled and queried.
  task automatic run_pressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    choose_box();
    poly_x.delete();
    poly_y.delete();
    send_item(pip_pkg::ACT_CLEAR, 0, 0);
    repeat (pip_pkg::MAX_VERTICES + 2) add_vertex();
    repeat (6) send_query();
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain();
    run_phase(0, 0, 260);
    run_phase(69, 0, 260);
    run_phase(0, 69, 260);
    run_phase(25, 25, 260);
    run_pressure();
    run_phase(0, 0, 60);
    repeat (20) @(posedge clk);
    if (verdicts.failures == 0 && verdicts.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
